// ===== rtl/sct_pkg.sv =====
// Shared types and codes for the sorted circle table.
`default_nettype none
package sct_pkg;

	localparam int COORD_W      = 16;
	localparam int READ_INDEX_W = 6;
	localparam int POSITION_W   = 6;
	localparam int FILL_W       = 7;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_READ   = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_FULL       = 2'd1,
		ST_NOT_FILLED = 2'd2
	} status_t;

	typedef struct packed {
		logic        [1:0]              op;
		logic signed [COORD_W-1:0]      centre_x;
		logic signed [COORD_W-1:0]      centre_y;
		logic        [COORD_W-1:0]      radius;
		logic        [READ_INDEX_W-1:0] read_index;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic        [COORD_W-1:0] r;
	} circle_t;

	typedef enum logic [1:0] {
		RD_IDX,
		RD_IDX_INC,
		RD_IDX_DEC,
		RD_INDEX
	} rd_sel_t;

	typedef enum logic {
		WR_SHIFT,
		WR_NEW
	} wr_sel_t;

	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_ZERO,
		IDX_INC,
		IDX_DEC,
		IDX_LAST
	} idx_op_t;

	typedef enum logic [1:0] {
		POS_HOLD,
		POS_COUNT,
		POS_IDX
	} pos_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_CLR,
		CNT_INC
	} cnt_op_t;

	// controller -> datapath
	typedef struct packed {
		logic    item_load;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wr_sel_t wr_sel;
		idx_op_t idx_op;
		pos_op_t pos_op;
		cnt_op_t cnt_op;
		logic    res_load;
		status_t res_status;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] op;
		logic       cnt_zero;
		logic       cnt_full;
		logic       rd_bad;
		logic       greater;
		logic       srch_last;
		logic       shift_done;
		logic       out_free;
	} stat_t;

endpackage
`default_nettype wire

// ===== rtl/sct_if.sv =====
// Handshake channels for input items and result items.
`default_nettype none
interface sct_in_if;
	import sct_pkg::*;
	logic                           valid;
	logic                           ready;
	logic        [1:0]              op;
	logic signed [COORD_W-1:0]      centre_x;
	logic signed [COORD_W-1:0]      centre_y;
	logic        [COORD_W-1:0]      radius;
	logic        [READ_INDEX_W-1:0] read_index;

	modport source (output valid, op, centre_x, centre_y, radius, read_index, input ready);
	modport sink   (input valid, op, centre_x, centre_y, radius, read_index, output ready);
endinterface

interface sct_out_if;
	import sct_pkg::*;
	logic                         valid;
	logic                         ready;
	logic        [1:0]            status;
	logic        [POSITION_W-1:0] position;
	logic        [FILL_W-1:0]     fill_count;
	logic signed [COORD_W-1:0]    out_x;
	logic signed [COORD_W-1:0]    out_y;
	logic        [COORD_W-1:0]    out_radius;

	modport source (output valid, status, position, fill_count, out_x, out_y, out_radius,
		input ready);
	modport sink   (input valid, status, position, fill_count, out_x, out_y, out_radius,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/sct_dpath.sv =====
// Datapath: circle memory, count, index and position registers, result register.
`default_nettype none
module sct_dpath import sct_pkg::*; #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cmd_t                         cmd,
	output stat_t                        stat,
	input  in_item_t                     in_item,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic        [1:0]            out_status,
	output logic        [POSITION_W-1:0] out_position,
	output logic        [FILL_W-1:0]     out_fill,
	output logic signed [COORD_W-1:0]    out_x,
	output logic signed [COORD_W-1:0]    out_y,
	output logic        [COORD_W-1:0]    out_radius
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int LW = (CW > READ_INDEX_W) ? CW : READ_INDEX_W;

	circle_t       mem [TABLE_DEPTH];
	circle_t       rdata_q;
	in_item_t      item_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] pos_q;
	logic [CW-1:0] count_q;
	logic          out_valid_q;

	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	circle_t       wr_data;

	always_comb begin
		unique case (cmd.rd_sel)
			RD_IDX:     rd_addr = idx_q;
			RD_IDX_INC: rd_addr = idx_q + AW'(1);
			RD_IDX_DEC: rd_addr = idx_q - AW'(1);
			RD_INDEX:   rd_addr = AW'(item_q.read_index);
		endcase
	end

	always_comb begin
		unique case (cmd.wr_sel)
			WR_SHIFT: begin
				wr_addr = idx_q + AW'(1);
				wr_data = rdata_q;
			end
			WR_NEW: begin
				wr_addr = pos_q;
				wr_data = '{x: item_q.centre_x, y: item_q.centre_y, r: item_q.radius};
			end
		endcase
	end

	// single write port, single registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			item_q <= in_item;
		end
		unique case (cmd.idx_op)
			IDX_HOLD: idx_q <= idx_q;
			IDX_ZERO: idx_q <= '0;
			IDX_INC:  idx_q <= idx_q + AW'(1);
			IDX_DEC:  idx_q <= idx_q - AW'(1);
			IDX_LAST: idx_q <= AW'(count_q - CW'(1));
			default:  idx_q <= idx_q;
		endcase
		unique case (cmd.pos_op)
			POS_HOLD:  pos_q <= pos_q;
			POS_COUNT: pos_q <= AW'(count_q);
			POS_IDX:   pos_q <= idx_q;
			default:   pos_q <= pos_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			unique case (cmd.cnt_op)
				CNT_HOLD: count_q <= count_q;
				CNT_CLR:  count_q <= '0;
				CNT_INC:  count_q <= count_q + CW'(1);
				default:  count_q <= count_q;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_status <= cmd.res_status;
			out_fill   <= FILL_W'(count_q);
			if (item_q.op == OP_READ) begin
				out_position <= POSITION_W'(item_q.read_index);
			end else if (item_q.op == OP_INSERT && cmd.res_status == ST_OK) begin
				out_position <= POSITION_W'(pos_q);
			end else begin
				out_position <= '0;
			end
			if (item_q.op == OP_READ && cmd.res_status == ST_OK) begin
				out_x      <= rdata_q.x;
				out_y      <= rdata_q.y;
				out_radius <= rdata_q.r;
			end else begin
				out_x      <= '0;
				out_y      <= '0;
				out_radius <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	assign stat.op         = item_q.op;
	assign stat.cnt_zero   = (count_q == '0);
	assign stat.cnt_full   = (count_q == CW'(TABLE_DEPTH));
	assign stat.rd_bad     = (LW'(item_q.read_index) >= LW'(count_q));
	assign stat.greater    = (rdata_q.y > item_q.centre_y) ||
		((rdata_q.y == item_q.centre_y) && (rdata_q.x > item_q.centre_x));
	assign stat.srch_last  = ((CW'(idx_q) + CW'(1)) == count_q);
	assign stat.shift_done = (idx_q == pos_q);
	assign stat.out_free   = !out_valid_q || out_ready;

endmodule
`default_nettype wire

// ===== rtl/sct_ctrl.sv =====
// Controller: sequences search, shift, write and result for each item.
`default_nettype none
module sct_ctrl import sct_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_SRCH_ISSUE,
		S_SRCH_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_WRITE,
		S_RD_ISSUE,
		S_FINISH
	} state_t;

	state_t  state_q, state_d;
	status_t status_q, status_d;

	always_comb begin
		state_d        = state_q;
		status_d       = status_q;
		cmd.item_load  = 1'b0;
		cmd.rd_en      = 1'b0;
		cmd.rd_sel     = RD_IDX;
		cmd.wr_en      = 1'b0;
		cmd.wr_sel     = WR_SHIFT;
		cmd.idx_op     = IDX_HOLD;
		cmd.pos_op     = POS_HOLD;
		cmd.cnt_op     = CNT_HOLD;
		cmd.res_load   = 1'b0;
		cmd.res_status = status_q;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.item_load = 1'b1;
					state_d       = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				status_d = ST_OK;
				priority if (stat.op == OP_INSERT) begin
					if (stat.cnt_full) begin
						status_d = ST_FULL;
						state_d  = S_FINISH;
					end else begin
						cmd.pos_op = POS_COUNT;
						cmd.idx_op = IDX_ZERO;
						state_d    = stat.cnt_zero ? S_WRITE : S_SRCH_ISSUE;
					end
				end else if (stat.op == OP_READ) begin
					if (stat.rd_bad) begin
						status_d = ST_NOT_FILLED;
						state_d  = S_FINISH;
					end else begin
						state_d = S_RD_ISSUE;
					end
				end else if (stat.op == OP_CLEAR) begin
					cmd.cnt_op = CNT_CLR;
					state_d    = S_FINISH;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_SRCH_ISSUE: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_IDX;
				state_d    = S_SRCH_CMP;
			end
			S_SRCH_CMP: begin
				// next entry is fetched while the current one is compared
				priority if (stat.greater) begin
					cmd.pos_op = POS_IDX;
					cmd.idx_op = IDX_LAST;
					state_d    = S_SHIFT_RD;
				end else if (stat.srch_last) begin
					state_d = S_WRITE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_IDX_INC;
					cmd.idx_op = IDX_INC;
				end
			end
			S_SHIFT_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_IDX;
				state_d    = S_SHIFT_WR;
			end
			S_SHIFT_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_SHIFT;
				if (stat.shift_done) begin
					state_d = S_WRITE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_IDX_DEC;
					cmd.idx_op = IDX_DEC;
				end
			end
			S_WRITE: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_NEW;
				cmd.cnt_op = CNT_INC;
				state_d    = S_FINISH;
			end
			S_RD_ISSUE: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_INDEX;
				state_d    = S_FINISH;
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= ST_OK;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

endmodule
`default_nettype wire

// ===== rtl/sorted_circle_table_insert.sv =====
// Top level of the sorted circle table.
// The table holds up to TABLE_DEPTH circles in one single-port-write,
// registered-read memory, kept sorted by centre_y and then centre_x (signed);
// an insert goes in front of the first strictly greater key, so equal keys stay
// in arrival order. Items are handled one at a time: an item is taken when the
// block is idle, and a finished result sits in an output register so the next
// item can be taken while it waits. An insert searches the valid entries for
// its slot and then shifts the entries from that slot up by one; an append
// behind the last entry skips the shift, and an insert into an empty table
// skips the search too. The memory's single read and write ports set the pace:
// the search walks entries one per cycle, and the shift moves one entry per
// cycle from the top down. A finished result waits while the output register
// still holds the previous one. A full table rejects an insert (status 1), a
// read at or past the fill count returns status 2. No clearing pass is needed
// after reset; the fill count alone marks which entries are valid.
`default_nettype none
module sorted_circle_table_insert import sct_pkg::*; #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	sct_in_if.sink    in_ch,
	sct_out_if.source out_ch
);

	cmd_t     cmd;
	stat_t    stat;
	in_item_t in_item;

	assign in_item = '{
		op:         in_ch.op,
		centre_x:   in_ch.centre_x,
		centre_y:   in_ch.centre_y,
		radius:     in_ch.radius,
		read_index: in_ch.read_index
	};

	sct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sct_dpath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.in_item      (in_item),
		.out_ready    (out_ch.ready),
		.out_valid    (out_ch.valid),
		.out_status   (out_ch.status),
		.out_position (out_ch.position),
		.out_fill     (out_ch.fill_count),
		.out_x        (out_ch.out_x),
		.out_y        (out_ch.out_y),
		.out_radius   (out_ch.out_radius)
	);

endmodule
`default_nettype wire

// ===== rtl/sct_check.sv =====
// Port-level checks for the sorted circle table, bound to the top level.
`default_nettype none
module sct_check import sct_pkg::*; #(
	parameter int TABLE_DEPTH = 64
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [1:0]            status,
	input logic [POSITION_W-1:0] position,
	input logic [FILL_W-1:0]     fill_count
);

	// one item at a time: taking an item closes the input side
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken twice in a row");

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(fill_count)
			&& $stable(position))
		else $error("stalled result changed");

	// a rejected insert only comes from a full table
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> fill_count == FILL_W'(TABLE_DEPTH))
		else $error("insert rejected below full");

	// a rejected read points at or past the fill count
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_NOT_FILLED |->
			(TABLE_DEPTH > 127) || ({1'b0, position} >= fill_count))
		else $error("read rejected inside filled part");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("unknown status code");

endmodule

bind sorted_circle_table_insert sct_check #(
	.TABLE_DEPTH (TABLE_DEPTH)
) u_check (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.status     (out_ch.status),
	.position   (out_ch.position),
	.fill_count (out_ch.fill_count)
);
`default_nettype wire

// ===== dv/circle_table_checker.sv =====
// Checker for the sorted circle table: predicts every reply and compares it.
`timescale 1ns / 100ps
module circle_table_checker import sct_pkg::*; #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	sct_in_if    in_ch,
	sct_out_if   out_ch,
	output int   fail_count,
	output int   replies_due
);

	typedef struct packed {
		status_t                    status;
		logic [POSITION_W-1:0]      position;
		logic [FILL_W-1:0]          fill_count;
		logic signed [COORD_W-1:0]  x;
		logic signed [COORD_W-1:0]  y;
		logic [COORD_W-1:0]         r;
	} table_reply_t;

	circle_t      shadow_table [TABLE_DEPTH];
	int           shadow_fill;
	table_reply_t expected_replies [$];
	int           fails = 0;

	assign fail_count = fails;

	// Applies one item to the shadow table and returns the reply it must cause.
	function automatic table_reply_t apply_item(in_item_t it);
		table_reply_t rep;
		int           slot;
		rep = '0;
		case (it.op)
		OP_INSERT: begin
			if (shadow_fill >= TABLE_DEPTH) begin
				rep.status = ST_FULL;
			end else begin
				// first strictly greater key; ties keep arrival order
				slot = shadow_fill;
				for (int i = 0; i < shadow_fill; i++) begin
					if (slot == shadow_fill &&
					    ($signed(shadow_table[i].y) > $signed(it.centre_y) ||
					     ($signed(shadow_table[i].y) == $signed(it.centre_y) &&
					      $signed(shadow_table[i].x) > $signed(it.centre_x))))
						slot = i;
				end
				for (int i = shadow_fill; i > slot; i--)
					shadow_table[i] = shadow_table[i-1];
				shadow_table[slot].x = it.centre_x;
				shadow_table[slot].y = it.centre_y;
				shadow_table[slot].r = it.radius;
				shadow_fill++;
				rep.position = POSITION_W'(slot);
			end
		end
		OP_READ: begin
			rep.position = it.read_index;
			if (int'(it.read_index) >= shadow_fill) begin
				rep.status = ST_NOT_FILLED;
			end else begin
				rep.x = shadow_table[it.read_index].x;
				rep.y = shadow_table[it.read_index].y;
				rep.r = shadow_table[it.read_index].r;
			end
		end
		OP_CLEAR: begin
			shadow_fill = 0;
		end
		default: begin
		end
		endcase
		rep.fill_count = FILL_W'(shadow_fill);
		return rep;
	endfunction

	function automatic void check_field(string name, logic [COORD_W-1:0] want,
		logic [COORD_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%h, got 0x%h", name, want, got);
			fails++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		table_reply_t want;
		in_item_t     taken;
		if (!arst_n) begin
			shadow_fill = 0;
			expected_replies.delete();
			replies_due <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_replies.size() == 0) begin
					$error("unexpected reply: status %0d position %0d fill %0d",
						out_ch.status, out_ch.position, out_ch.fill_count);
					fails++;
				end else begin
					want = expected_replies.pop_front();
					check_field("status",     want.status,     out_ch.status);
					check_field("position",   want.position,   out_ch.position);
					check_field("fill_count", want.fill_count, out_ch.fill_count);
					check_field("out_x",      want.x,          out_ch.out_x);
					check_field("out_y",      want.y,          out_ch.out_y);
					check_field("out_radius", want.r,          out_ch.out_radius);
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				taken.op         = in_ch.op;
				taken.centre_x   = in_ch.centre_x;
				taken.centre_y   = in_ch.centre_y;
				taken.radius     = in_ch.radius;
				taken.read_index = in_ch.read_index;
				expected_replies.push_back(apply_item(taken));
			end
			replies_due <= expected_replies.size();
		end
	end

endmodule

// ===== dv/tb_sorted_circle_table_insert.sv =====
// Testbench top for the sorted circle table: stimulus, idling and the verdict.
`timescale 1ns / 100ps
module tb_sorted_circle_table_insert;
	import sct_pkg::*;

	localparam int         TABLE_DEPTH = 64;
	localparam int         ITEM_TARGET = 800;
	// worst insert walks and shifts the whole table
	localparam int         TAIL_CYCLES = 2 * TABLE_DEPTH + 16;
	localparam int         HOLD_CYCLES = 400;
	localparam int         CYCLE_LIMIT = 600000;
	// op code the block ignores
	localparam logic [1:0] OP_SPARE    = 2'd3;

	logic clk;
	logic arst_n;

	sct_in_if  in_ch ();
	sct_out_if out_ch ();

	int fail_count;
	int replies_due;

	// idle rates in percent, changed per phase
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	// request for one long receiver hold-off
	bit hold_req     = 1'b0;
	// items counted toward the target (ignored op codes excluded)
	int sent         = 0;
	// entry count as seen by the stimulus, used only to aim reads
	int rows         = 0;

	sorted_circle_table_insert #(.TABLE_DEPTH(TABLE_DEPTH)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	circle_table_checker #(.TABLE_DEPTH(TABLE_DEPTH)) i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.fail_count  (fail_count),
		.replies_due (replies_due)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Run limit: counts cycles in its own process and gives up when exceeded.
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	// Receiver side. Ready is rolled every cycle; a hold-off request drops it
	// for a long stretch so the block's output register fills and the block
	// stops taking items while the sender keeps offering.
	initial begin
		int hold;
		hold = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold     = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
			end
		end
	end

	// Offers one item: random idle gaps first, then valid stays high until
	// the block takes the item. Valid is not lowered here, so back-to-back
	// items never see a low and a high in the same step.
	task automatic put_item(in_item_t it);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.op         <= it.op;
		in_ch.centre_x   <= it.centre_x;
		in_ch.centre_y   <= it.centre_y;
		in_ch.radius     <= it.radius;
		in_ch.read_index <= it.read_index;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		if (it.op != OP_SPARE)
			sent++;
		case (it.op)
		OP_INSERT: begin
			if (rows < TABLE_DEPTH)
				rows++;
		end
		OP_CLEAR: begin
			rows = 0;
		end
		default: begin
		end
		endcase
	endtask

	// All fields random; unused fields of each op carry noise on purpose.
	function automatic in_item_t noise_item(logic [1:0] op);
		in_item_t it;
		it.op         = op;
		it.centre_x   = COORD_W'($urandom);
		it.centre_y   = COORD_W'($urandom);
		it.radius     = COORD_W'($urandom);
		it.read_index = READ_INDEX_W'($urandom);
		return it;
	endfunction

	task automatic send_insert(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
		logic [COORD_W-1:0] r);
		in_item_t it;
		it          = noise_item(OP_INSERT);
		it.centre_x = x;
		it.centre_y = y;
		it.radius   = r;
		put_item(it);
	endtask

	task automatic send_read(int idx);
		in_item_t it;
		it            = noise_item(OP_READ);
		it.read_index = READ_INDEX_W'(idx);
		put_item(it);
	endtask

	task automatic send_op(logic [1:0] op);
		put_item(noise_item(op));
	endtask

	// Sender pause: stop offering until every reply is back. The first edge
	// lets the count of outstanding replies catch up with the last item.
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (replies_due != 0)
			@(posedge clk);
	endtask

	// Coordinates: full range, a narrow band around zero so keys collide
	// (equal y, equal x, exact duplicates), and the two extremes.
	function automatic logic [COORD_W-1:0] pick_coord();
		case ($urandom_range(0, 9))
		0, 1, 2, 3: return COORD_W'($urandom);
		8:          return 16'h8000;
		9:          return 16'h7fff;
		default:    return COORD_W'($urandom_range(0, 6) - 3);
		endcase
	endfunction

	// Mostly aim at filled slots; the rest anywhere, past the fill included.
	function automatic int pick_index();
		if (rows > 0 && $urandom_range(0, 99) < 80)
			return $urandom_range(0, rows - 1);
		return $urandom_range(0, 63);
	endfunction

	// One well-formed run: optional clear, a burst of inserts with reads and
	// a few ignored op codes mixed in.
	task automatic run_episode(int inserts, bit wipe);
		if (wipe)
			send_op(OP_CLEAR);
		for (int k = 0; k < inserts; k++) begin
			send_insert(pick_coord(), pick_coord(), COORD_W'($urandom));
			if ($urandom_range(0, 99) < 30)
				send_read(pick_index());
			if ($urandom_range(0, 99) < 3)
				send_op(OP_SPARE);
		end
	endtask

	task automatic random_episode();
		int n;
		// now and then a long run that can fill the table and overflow it
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(55, 70) : $urandom_range(1, 16);
		run_episode(n, $urandom_range(0, 99) < 60);
	endtask

	initial begin
		in_ch.valid      <= 1'b0;
		in_ch.op         <= OP_INSERT;
		in_ch.centre_x   <= '0;
		in_ch.centre_y   <= '0;
		in_ch.radius     <= '0;
		in_ch.read_index <= '0;
		arst_n           <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part ----
		snd_idle_pct = 31;
		rcv_idle_pct = 57;
		send_read(0);                                // read on an empty table
		send_insert(16'h0000, 16'h0000, 16'h0000);
		send_insert(16'h7fff, 16'h7fff, 16'hffff);   // largest key goes last
		send_insert(16'h8000, 16'h8000, 16'h5555);   // smallest key goes first
		send_insert(16'h0005, 16'h0000, 16'h0001);   // same y, larger x
		send_insert(16'h0000, 16'h0000, 16'h0002);   // duplicate key: after the first
		send_insert(16'hffff, 16'h0000, 16'haaaa);   // same y, negative x
		send_insert(16'h7fff, 16'hffff, 16'h0003);   // y = -1 sorts before y = 0
		send_read(0);
		send_read(3);
		send_read(4);
		send_read(6);                                // last filled slot
		send_read(7);                                // just past the fill
		send_read(63);                               // highest index, not filled
		send_op(OP_SPARE);                           // ignored op code
		send_op(OP_CLEAR);
		send_read(0);                                // nothing left after clear
		send_op(OP_CLEAR);                           // clear of an empty table
		send_insert(16'h1234, 16'hedcb, 16'h8001);
		send_read(0);
		drain();

		// ---- random part, phase 1: sender idles less than receiver ----
		// Fill the table to the top and push two inserts past it.
		run_episode(TABLE_DEPTH + 2, 1'b1);
		send_read(TABLE_DEPTH - 1);
		send_read(0);
		// long receiver hold-off while items keep coming
		hold_req = 1'b1;
		random_episode();
		while (sent < ITEM_TARGET / 3)
			random_episode();
		drain();

		// ---- phase 2: the other way round ----
		snd_idle_pct = 57;
		rcv_idle_pct = 31;
		while (sent < 2 * ITEM_TARGET / 3)
			random_episode();
		drain();

		// ---- phase 3: no idling on either side ----
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		while (sent < ITEM_TARGET)
			random_episode();

		// wait for every reply, then give stray replies time to show up
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== sorted_circle_table_insert.f =====
rtl/sct_pkg.sv
rtl/sct_if.sv
rtl/sct_dpath.sv
rtl/sct_ctrl.sv
rtl/sorted_circle_table_insert.sv
rtl/sct_check.sv
dv/circle_table_checker.sv
dv/tb_sorted_circle_table_insert.sv
